FILE: rtl/seu_pkg.sv
// Shared types and character constants for the string escape unescaper.
package seu_pkg;

   // Parser phases, one-hot
   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_CR   = 5'b00010,
      PH_BS   = 5'b00100,
      PH_BSU  = 5'b01000,
      PH_HEX  = 5'b10000
   } phase_type;

   // Commands from the parser to the serializer
   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,   // one byte, cp[7:0]
      OP_PAIR = 2'd1,   // 'u' followed by cp[7:0]
      OP_UTF8 = 2'd2    // UTF-8 encoding of cp, one to six bytes
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] cp;
   } cmd_type;

   // One queue slot as seen from either side
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } slot_type;

   localparam logic [7:0] CHAR_BS     = 8'h5C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;

endpackage

FILE: rtl/seu_front.sv
// Front end: byte classifier, escape parser and code point accumulator.
module seu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_raw_mode,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output seu_pkg::slot_type push_slot
);
   import seu_pkg::*;

   localparam int HEX_BITS = 4;   // one digit of radix 16

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } esc_type;

   typedef struct packed {
      logic                valid;
      logic [HEX_BITS-1:0] value;
   } hex_type;

   function automatic esc_type escape_map(input logic [7:0] b);
      esc_type r;
      r.valid = 1'b1;
      unique case (b)
         8'h30:   r.value = 8'h00;   // '0'
         8'h5C:   r.value = 8'h5C;   // backslash
         8'h62:   r.value = 8'h08;   // 'b'
         8'h66:   r.value = 8'h0C;   // 'f'
         8'h6E:   r.value = 8'h0A;   // 'n'
         8'h72:   r.value = 8'h0D;   // 'r'
         8'h74:   r.value = 8'h09;   // 't'
         8'h76:   r.value = 8'h0B;   // 'v'
         8'h27:   r.value = 8'h27;   // single quote
         8'h22:   r.value = 8'h22;   // double quote
         8'h3F:   r.value = 8'h3F;   // '?'
         default: begin
            r.valid = 1'b0;
            r.value = 8'h00;
         end
      endcase
      return r;
   endfunction

   function automatic hex_type hex_value(input logic [7:0] b);
      hex_type r;
      r.valid = 1'b1;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.value = HEX_BITS'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r.value = HEX_BITS'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r.value = HEX_BITS'(b - 8'h37);
      end else begin
         r.valid = 1'b0;
         r.value = '0;
      end
      return r;
   endfunction

   logic        raw_mode_ff;
   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in, acc_shift;
   logic        plain_emit;
   logic [7:0]  plain_byte;
   phase_type   plain_next;
   esc_type     esc;
   hex_type     hx;
   logic        emit;
   cmd_type     cmd;

   assign esc       = escape_map(in_byte);
   assign hx        = hex_value(in_byte);
   assign acc_shift = {acc_ff[31-HEX_BITS:0], hx.value};

   // Ordinary byte handling from the idle phase
   always_comb begin
      plain_emit = 1'b1;
      plain_byte = in_byte;
      plain_next = PH_IDLE;
      if (in_byte == CHAR_BS && !raw_mode_ff && !in_last) begin
         plain_emit = 1'b0;
         plain_next = PH_BS;
      end else if (in_byte == CHAR_CR) begin
         plain_byte = CHAR_LF;
         plain_next = PH_CR;
      end
   end

   // Advance the phase and build the command for this byte
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      emit     = 1'b0;
      cmd.op   = OP_BYTE;
      cmd.cp   = {24'b0, plain_byte};
      unique case (phase_ff)
         PH_CR: begin
            if (in_byte == CHAR_LF) begin
               phase_in = PH_IDLE;
            end else begin
               emit     = plain_emit;
               phase_in = plain_next;
            end
         end
         PH_BS: begin
            if (in_byte == CHAR_U && !in_last) begin
               phase_in = PH_BSU;
            end else if (esc.valid) begin
               emit     = 1'b1;
               cmd.cp   = {24'b0, esc.value};
               phase_in = PH_IDLE;
            end else begin
               emit     = plain_emit;
               phase_in = plain_next;
            end
         end
         PH_BSU: begin
            if (in_byte == CHAR_LBRACE) begin
               acc_in   = '0;
               phase_in = PH_HEX;
               if (in_last) begin
                  emit   = 1'b1;
                  cmd.op = OP_UTF8;
                  cmd.cp = '0;
               end
            end else begin
               emit     = 1'b1;
               phase_in = plain_next;
               if (plain_emit) begin
                  cmd.op = OP_PAIR;
               end else begin
                  cmd.cp = {24'b0, CHAR_U};
               end
            end
         end
         PH_HEX: begin
            if (hx.valid) begin
               acc_in = acc_shift;
               if (in_last) begin
                  emit   = 1'b1;
                  cmd.op = OP_UTF8;
                  cmd.cp = acc_shift;
               end
            end else begin
               emit     = 1'b1;
               cmd.op   = OP_UTF8;
               cmd.cp   = acc_ff;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            emit     = plain_emit;
            phase_in = plain_next;
         end
      endcase
      if (in_last) begin
         phase_in = PH_IDLE;
      end
   end

   // Drop code points that have no UTF-8 form
   assign push_slot.valid = accept && emit && !(cmd.op == OP_UTF8 && cmd.cp[31]);
   assign push_slot.cmd   = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         acc_ff      <= '0;
      end else begin
         if (csr_we) begin
            raw_mode_ff <= csr_raw_mode;
         end
         if (accept) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
         end
      end
   end

   // The string end always closes any open escape
   assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> phase_ff == PH_IDLE)
      else $error("phase not idle after last byte");

endmodule

FILE: rtl/seu_queue.sv
// Command queue between the parser and the serializer.
module seu_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  seu_pkg::slot_type push_slot,
   output logic              full,
   output seu_pkg::slot_type head,
   input  logic              pop
);
   import seu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push_slot.valid) begin
         mem_ff[wr_ptr_ff] <= push_slot.cmd;
      end
   end

   // Advance pointers and the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_slot.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_slot.valid && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push_slot.valid) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) push_slot.valid |-> !full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> head.valid)
      else $error("pop from empty queue");

endmodule

FILE: rtl/seu_back.sv
// Back end: expands commands into result bytes, one per transfer.
module seu_back (
   input  logic              clock,
   input  logic              reset,
   input  seu_pkg::slot_type head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_out_last
);
   import seu_pkg::*;

   function automatic logic [2:0] utf8_len(input logic [31:0] cp);
      logic [2:0] len;
      if (cp <= 32'h7F) len = 3'd1;
      else if (cp <= 32'h7FF) len = 3'd2;
      else if (cp <= 32'hFFFF) len = 3'd3;
      else if (cp <= 32'h1F_FFFF) len = 3'd4;
      else if (cp <= 32'h3FF_FFFF) len = 3'd5;
      else len = 3'd6;
      return len;
   endfunction

   logic        busy_ff;
   op_type      op_ff;
   logic [31:0] cp_ff;
   logic [2:0]  rem_ff, rem_load;
   logic        first_ff;
   logic [31:0] shifted;
   logic [7:0]  lead_mask;
   logic        done;

   assign rsp_empty    = !busy_ff;
   assign rsp_out_last = (rem_ff == 3'd0);
   assign done         = busy_ff && rsp_pop && (rem_ff == 3'd0);
   assign q_pop        = head.valid && (!busy_ff || done);

   // Bytes still to follow the first one of the new command
   always_comb begin
      case (head.cmd.op)
         OP_PAIR: rem_load = 3'd1;
         OP_UTF8: rem_load = utf8_len(head.cmd.cp) - 3'd1;
         default: rem_load = 3'd0;
      endcase
   end

   // Select the six-bit group for the current byte
   always_comb begin
      case (rem_ff)
         3'd1:    shifted = {6'b0, cp_ff[31:6]};
         3'd2:    shifted = {12'b0, cp_ff[31:12]};
         3'd3:    shifted = {18'b0, cp_ff[31:18]};
         3'd4:    shifted = {24'b0, cp_ff[31:24]};
         3'd5:    shifted = {30'b0, cp_ff[31:30]};
         default: shifted = cp_ff;
      endcase
   end

   // Lead byte marker for a sequence of rem_ff + 1 bytes
   always_comb begin
      case (rem_ff)
         3'd1:    lead_mask = 8'hC0;
         3'd2:    lead_mask = 8'hE0;
         3'd3:    lead_mask = 8'hF0;
         3'd4:    lead_mask = 8'hF8;
         3'd5:    lead_mask = 8'hFC;
         default: lead_mask = 8'h00;
      endcase
   end

   always_comb begin
      case (op_ff)
         OP_PAIR: rsp_out_byte = first_ff ? CHAR_U : cp_ff[7:0];
         OP_UTF8: rsp_out_byte = first_ff ? (lead_mask | shifted[7:0])
                                          : {2'b10, shifted[5:0]};
         default: rsp_out_byte = cp_ff[7:0];
      endcase
   end

   // Load the next command or step through the current one
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         rem_ff   <= '0;
         first_ff <= 1'b0;
      end else if (q_pop) begin
         busy_ff  <= 1'b1;
         rem_ff   <= rem_load;
         first_ff <= 1'b1;
      end else if (busy_ff && rsp_pop) begin
         if (rem_ff == 3'd0) begin
            busy_ff <= 1'b0;
         end else begin
            rem_ff   <= rem_ff - 3'd1;
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff <= head.cmd.op;
         cp_ff <= head.cmd.cp;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      busy_ff && op_ff == OP_PAIR |-> rem_ff <= 3'd1)
      else $error("pair command longer than two bytes");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff && !first_ff |-> op_ff != OP_BYTE)
      else $error("single byte command continued");

endmodule

FILE: rtl/string_escape_unescaper.sv
// Top level of the string escape unescaper.
// Source bytes enter on the req_ channel: an item transfers when req_push is
// high and req_full is low; req_in_last marks the final byte of a string.
// Normalized bytes leave on the rsp_ channel: while rsp_empty is low the
// oldest byte is on rsp_out_byte, and it transfers when rsp_pop is high.
// rsp_out_last is high on the last byte produced by one source byte.
// csr_we writes csr_raw_mode; in raw mode backslashes pass through.
// An accepted source byte is stored in the command queue, then loaded into
// the serializer before its first result appears. The parser takes one byte
// per cycle while req_full is low; the serializer sends one result byte per
// cycle while rsp_pop is high. Sustained rate is one source byte per cycle
// while each gives at most one result byte; else the serializer sets it.
// The command queue (QUEUE_DEPTH entries) lets the parser run ahead while
// the receiver stalls; req_full rises only when that queue is full.
// Synchronous reset empties the queue, clears raw mode and returns the
// parser to idle; there is no clearing pass.
module string_escape_unescaper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   input  logic       csr_we,
   input  logic       csr_raw_mode
);
   import seu_pkg::*;

   slot_type push_slot;
   slot_type head;
   logic     q_pop;
   logic     accept;

   assign accept = req_push && !req_full;

   seu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_raw_mode (csr_raw_mode),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .in_last      (req_in_last),
      .push_slot    (push_slot)
   );

   seu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_slot (push_slot),
      .full      (req_full),
      .head      (head),
      .pop       (q_pop)
   );

   seu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

FILE: verif/string_escape_unescaper_tb.sv
// Self-checking testbench for the string escape unescaper: directed and random strings.
`timescale 1ns / 100ps

module string_escape_unescaper_tb;
   import seu_pkg::*;

   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_REPORTS  = 10;

   // Known escape letters, in the order of the mapping table
   localparam logic [7:0] ESC_LETTERS [11] =
      '{"0", "\\", "b", "f", "n", "r", "t", "v", "'", "\"", "?"};
   // Letters that name no escape
   localparam logic [7:0] BAD_LETTERS [6] = '{"a", "c", "q", "x", "z", "U"};

   typedef struct packed {
      logic [7:0] value;
      logic       is_last;
   } result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       csr_we = 1'b0;
   logic       csr_raw_mode = 1'b0;

   // Shadow state of the unescaper
   phase_type   model_phase = PH_IDLE;
   logic [31:0] model_acc = 32'h0;
   logic        model_raw = 1'b0;

   result_type  predicted_bytes[$];
   logic [7:0]  step_bytes[$];
   result_type  head;

   int  bytes_sent = 0;
   int  bytes_checked = 0;
   int  config_writes = 0;
   int  error_count = 0;
   int  pop_wait = 0;
   bit  send_steady = 1'b0;
   bit  pop_steady = 1'b0;

   string_escape_unescaper u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .csr_we       (csr_we),
      .csr_raw_mode (csr_raw_mode)
   );

   always #1 clock = ~clock;

   // Hard stop in case the block hangs
   initial begin
      #200000;
      $display("status: fail");
      $finish;
   end

   function automatic void report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
   endfunction

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------
   function automatic int hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic int escape_code(input logic [7:0] c);
      case (c)
         "0":     return 8'h00;
         "\\":    return CHAR_BS;
         "b":     return 8'h08;
         "f":     return 8'h0C;
         "n":     return CHAR_LF;
         "r":     return CHAR_CR;
         "t":     return 8'h09;
         "v":     return 8'h0B;
         "'":     return 8'h27;
         "\"":    return 8'h22;
         "?":     return 8'h3F;
         default: return -1;
      endcase
   endfunction

   // Append one byte to the results of the current source byte
   function automatic void add_step_byte(input logic [7:0] value);
      step_bytes.insert(step_bytes.size(), value);
   endfunction

   // Ordinary byte from the idle phase
   function automatic void emit_plain(input logic [7:0] value, input logic last);
      if (value == CHAR_BS && !model_raw && !last) begin
         model_phase = PH_BS;
      end else if (value == CHAR_CR) begin
         model_phase = PH_CR;
         add_step_byte(CHAR_LF);
      end else begin
         model_phase = PH_IDLE;
         add_step_byte(value);
      end
   endfunction

   // Original UTF-8 form, up to six bytes; nothing above 31 bits
   function automatic void emit_utf8(input logic [31:0] cp);
      int          len;
      logic [31:0] lead;
      logic [31:0] tail;
      if (cp <= 32'h7F) begin
         add_step_byte(cp[7:0]);
         return;
      end
      if (cp > 32'h7FFF_FFFF) return;
      if (cp <= 32'h7FF) len = 2;
      else if (cp <= 32'hFFFF) len = 3;
      else if (cp <= 32'h1F_FFFF) len = 4;
      else if (cp <= 32'h3FF_FFFF) len = 5;
      else len = 6;
      lead = ((32'hFF00 >> len) & 32'hFF) | (cp >> (6 * (len - 1)));
      add_step_byte(lead[7:0]);
      for (int k = len - 2; k >= 0; k--) begin
         tail = 32'h80 | ((cp >> (6 * k)) & 32'h3F);
         add_step_byte(tail[7:0]);
      end
   endfunction

   // Advance the shadow state by one source byte and queue its results
   function automatic void unescape_predict(input logic [7:0] value, input logic last);
      int         mapped;
      int         digit;
      result_type entry;
      step_bytes.delete();
      case (model_phase)
         PH_CR: begin
            if (value == CHAR_LF) model_phase = PH_IDLE;
            else emit_plain(value, last);
         end
         PH_BS: begin
            mapped = escape_code(value);
            if (value == CHAR_U && !last) begin
               model_phase = PH_BSU;
            end else if (mapped >= 0) begin
               add_step_byte(mapped[7:0]);
               model_phase = PH_IDLE;
            end else begin
               emit_plain(value, last);
            end
         end
         PH_BSU: begin
            if (value == CHAR_LBRACE) begin
               model_acc = 32'h0;
               if (last) emit_utf8(32'h0);
               model_phase = PH_HEX;
            end else begin
               add_step_byte(CHAR_U);
               emit_plain(value, last);
            end
         end
         PH_HEX: begin
            digit = hex_digit(value);
            if (digit >= 0) begin
               model_acc = model_acc * 32'd16 + 32'(digit);
               if (last) emit_utf8(model_acc);
            end else begin
               emit_utf8(model_acc);
               model_phase = PH_IDLE;
            end
         end
         default: emit_plain(value, last);
      endcase
      if (last) model_phase = PH_IDLE;
      foreach (step_bytes[i]) begin
         entry.value   = step_bytes[i];
         entry.is_last = (i == step_bytes.size() - 1);
         predicted_bytes.insert(predicted_bytes.size(), entry);
      end
   endfunction

   // ---------------------------------------------------------------
   // Result side: pop with random stalls, check every transfer
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= (pop_wait == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         pop_wait <= pop_steady ? 0 : $urandom_range(0, 8);
         bytes_checked++;
         if (predicted_bytes.size() == 0) begin
            report_error($sformatf("unexpected result %02h last=%0b",
                                   rsp_out_byte, rsp_out_last));
         end else begin
            head = predicted_bytes.pop_front();
            if (rsp_out_byte !== head.value || rsp_out_last !== head.is_last) begin
               report_error($sformatf("expected %02h last=%0b, got %02h last=%0b",
                                      head.value, head.is_last,
                                      rsp_out_byte, rsp_out_last));
            end
         end
      end else if (!rsp_pop && pop_wait > 0) begin
         pop_wait <= pop_wait - 1;
      end
   end

   // ---------------------------------------------------------------
   // Source side
   // ---------------------------------------------------------------
   // Push one byte after a random gap; leave push high for a back-to-back transfer
   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push    <= 1'b1;
      req_in_byte <= value;
      req_in_last <= last;
      do @(posedge clock); while (req_full);
      unescape_predict(value, last);
      bytes_sent++;
   endtask

   task automatic send_string(input logic [7:0] text[$]);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   // Drain everything in flight, then write the raw-mode register
   task automatic set_raw_mode(input logic value);
      @(negedge clock);
      req_push <= 1'b0;
      while (predicted_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we       <= 1'b1;
      csr_raw_mode <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      model_raw = value;
      config_writes++;
   endtask

   function automatic logic [7:0] random_hex_char();
      int d;
      d = $urandom_range(0, 15);
      if (d < 10) return 8'(int'("0") + d);
      if ($urandom_range(0, 1) == 1) return 8'(int'("A") + d - 10);
      return 8'(int'("a") + d - 10);
   endfunction

   // Mostly well-formed escapes with random content, some noise and broken ones
   task automatic build_random_string(output logic [7:0] text[$]);
      int segments;
      int kind;
      int digits;
      text.delete();
      segments = $urandom_range(1, 6);
      repeat (segments) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            text.insert(text.size(), 8'($urandom_range(0, 255)));
         end else if (kind < 45) begin
            text.insert(text.size(), CHAR_BS);
            text.insert(text.size(), ESC_LETTERS[$urandom_range(0, 10)]);
         end else if (kind < 70) begin
            text.insert(text.size(), CHAR_BS);
            text.insert(text.size(), CHAR_U);
            text.insert(text.size(), CHAR_LBRACE);
            digits = $urandom_range(0, 9);
            repeat (digits) text.insert(text.size(), random_hex_char());
            kind = $urandom_range(0, 9);
            if (kind < 6) text.insert(text.size(), "}");
            else if (kind < 8) text.insert(text.size(), 8'($urandom_range(0, 255)));
         end else if (kind < 80) begin
            text.insert(text.size(), CHAR_CR);
            if ($urandom_range(0, 1) == 1) text.insert(text.size(), CHAR_LF);
         end else if (kind < 90) begin
            text.insert(text.size(), CHAR_BS);
            if ($urandom_range(0, 1) == 1) begin
               text.insert(text.size(), BAD_LETTERS[$urandom_range(0, 5)]);
            end else begin
               text.insert(text.size(), CHAR_U);
               text.insert(text.size(), 8'($urandom_range(0, 255)));
            end
         end else begin
            text.insert(text.size(), CHAR_BS);
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Escape letters, byte extremes, line endings, unknown and dangling escapes
   task automatic test_simple_escapes();
      logic [7:0] text[$];
      text = '{CHAR_BS, "0", 8'hFF, 8'h00, CHAR_CR, CHAR_LF, CHAR_CR, "A"};
      send_string(text);
      text = '{CHAR_BS, "q", CHAR_BS, CHAR_U, "x", CHAR_BS};
      send_string(text);
   endtask

   // Hex escape closed by string end, and escapes cut off by string end
   task automatic test_unicode_escapes();
      logic [7:0] text[$];
      text = '{CHAR_BS, CHAR_U, CHAR_LBRACE, "1", "0", "f", "F", "F", "F"};
      send_string(text);
      text = '{CHAR_BS, CHAR_U};
      send_string(text);
      text = '{CHAR_BS, CHAR_U, CHAR_LBRACE};
      send_string(text);
   endtask

   // Backslash passes through in raw mode; CR still becomes LF
   task automatic test_raw_mode();
      logic [7:0] text[$];
      set_raw_mode(1'b1);
      text = '{CHAR_BS, "n", CHAR_CR};
      send_string(text);
   endtask

   // Random strings over alternating raw-mode settings
   task automatic test_random_strings();
      logic [7:0] text[$];
      int goal;
      for (int round = 0; round < 4; round++) begin
         set_raw_mode(round[0]);
         goal = bytes_sent + 20;
         while (bytes_sent < goal) begin
            send_steady = ($urandom_range(0, 3) == 0);
            pop_steady  = ($urandom_range(0, 3) == 0);
            build_random_string(text);
            send_string(text);
         end
      end
      send_steady = 1'b0;
      pop_steady  = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_simple_escapes();
      test_unicode_escapes();
      test_raw_mode();
      test_random_strings();

      // Drain and allow for stray results
      @(negedge clock);
      req_push <= 1'b0;
      while (predicted_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES * 2) @(negedge clock);

      $display("Sent %0d source bytes, checked %0d result bytes, %0d raw-mode writes.",
               bytes_sent, bytes_checked, config_writes);
      $display("Errors seen: %0d", error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
